FILE: sv/tmts_pkg.sv
// Shared types and constants for the multi-tape Turing step unit.
package tmts_pkg;

  localparam int NUM_TAPES   = 4;
  localparam int TAPE_DEPTH  = 4096;
  localparam int TAPE_ORIGIN = 2048;
  localparam int NUM_RULES   = 256;
  localparam int SYM_BITS    = 4;
  localparam int STATE_BITS  = 8;

  localparam int TAPE_ABITS  = $clog2(TAPE_DEPTH);
  localparam int RULE_ABITS  = $clog2(NUM_RULES);
  localparam int ORIGIN_EFF  = (TAPE_ORIGIN < TAPE_DEPTH) ? TAPE_ORIGIN : TAPE_DEPTH - 1;

  localparam logic [3:0] WILD_CODE = 4'hF;

  localparam logic [2:0] OP_LOAD_RULE  = 3'd0;
  localparam logic [2:0] OP_WRITE_CELL = 3'd1;
  localparam logic [2:0] OP_START      = 3'd2;
  localparam logic [2:0] OP_STEP       = 3'd3;
  localparam logic [2:0] OP_READ_CELL  = 3'd4;

  localparam logic [1:0] MOVE_LEFT  = 2'd1;
  localparam logic [1:0] MOVE_RIGHT = 2'd2;

  localparam logic [1:0] CFG_INITIAL_STATE = 2'd0;
  localparam logic [1:0] CFG_TAPES_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_RULES_IN_USE  = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  rule_index;
    logic [7:0]  rule_from_state;
    logic [15:0] rule_match_symbols;
    logic [15:0] rule_write_symbols;
    logic [7:0]  rule_moves;
    logic [7:0]  rule_next_state;
    logic [1:0]  cell_tape;
    logic [11:0] cell_address;
    logic [3:0]  cell_symbol;
  } in_word_t;

  typedef struct packed {
    logic        halted;
    logic        head_fault;
    logic [7:0]  present_state;
    logic [31:0] steps_taken;
    logic [3:0]  read_symbol;
    logic [7:0]  fired_rule;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  from_state;
    logic [15:0] match;
    logic [15:0] write;
    logic [7:0]  moves;
    logic [7:0]  next_state;
  } rule_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_READ,
    S_SCAN,
    S_APPLY,
    S_DONE
  } fsm_t;

endpackage

FILE: sv/tmts_ram.sv
// Single-port synchronous RAM with registered read data.
module tmts_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: sv/multi_tape_turing_step_unit.sv
// Multi-tape Turing step unit: rule and tape memories with a command sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall   | in_word  (tmts_pkg::in_word_t)
//  out     | output    | out_valid/out_stall | out_word (tmts_pkg::out_word_t)
//  cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// Load rule, write cell and unknown codes, read cell, and a step while halted each
// finish through S_DONE. A step scans the rules, one rule per cycle through the rule
// RAM port, up to and including the one that fires, and then applies it; a step with
// no match halts. Start runs a tape clearing pass over all TAPE_DEPTH (4096) addresses,
// all tapes in parallel; reset runs the same pass. No word is accepted meanwhile.
// A finished word waits in the output register under stall.
module multi_tape_turing_step_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tmts_pkg::in_word_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output tmts_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [8:0]         cfg_data
);

  tmts_pkg::fsm_t state, state_next;

  logic [7:0] initial_state;
  logic [2:0] tapes_in_use;
  logic [8:0] rules_in_use;

  logic [tmts_pkg::TAPE_ABITS-1:0] head [tmts_pkg::NUM_TAPES];
  logic [tmts_pkg::STATE_BITS-1:0] mstate;
  logic [31:0] steps;
  logic        halt_flag;
  logic        fault_flag;
  logic [3:0]  read_sym;
  logic [7:0]  fired;
  logic [8:0]  scan_idx;
  logic [8:0]  scan_idx_next;
  logic [tmts_pkg::TAPE_ABITS-1:0] clr_cnt;
  logic        clr_report;
  logic [1:0]  cell_tape_q;
  tmts_pkg::rule_t act_rule;

  logic                             rule_we;
  logic [tmts_pkg::RULE_ABITS-1:0]  rule_addr;
  tmts_pkg::rule_t                  rule_wdata;
  tmts_pkg::rule_t                  rule_rdata;

  logic                             tape_we    [tmts_pkg::NUM_TAPES];
  logic [tmts_pkg::TAPE_ABITS-1:0]  tape_addr  [tmts_pkg::NUM_TAPES];
  logic [tmts_pkg::SYM_BITS-1:0]    tape_wdata [tmts_pkg::NUM_TAPES];
  logic [tmts_pkg::SYM_BITS-1:0]    tape_rdata [tmts_pkg::NUM_TAPES];

  logic       accept;
  logic [2:0] nt;
  logic [8:0] limit;
  logic       rule_hit;
  logic       out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != tmts_pkg::S_IDLE);
  assign out_free = !out_valid || !out_stall;
  assign scan_idx_next = scan_idx + 9'd1;

  assign nt = (tapes_in_use == 3'd0) ? 3'd1 :
              (tapes_in_use > 3'd4) ? 3'd4 : tapes_in_use;
  assign limit = (rules_in_use > 9'(tmts_pkg::NUM_RULES)) ? 9'(tmts_pkg::NUM_RULES)
                                                          : rules_in_use;

  tmts_ram #(.DEPTH(tmts_pkg::NUM_RULES), .WIDTH($bits(tmts_pkg::rule_t))) u_rules (
    .clk   (clk),
    .we    (rule_we),
    .addr  (rule_addr),
    .wdata (rule_wdata),
    .rdata (rule_rdata)
  );

  for (genvar g = 0; g < tmts_pkg::NUM_TAPES; g++) begin : g_tape
    tmts_ram #(.DEPTH(tmts_pkg::TAPE_DEPTH), .WIDTH(tmts_pkg::SYM_BITS)) u_tape (
      .clk   (clk),
      .we    (tape_we[g]),
      .addr  (tape_addr[g]),
      .wdata (tape_wdata[g]),
      .rdata (tape_rdata[g])
    );
  end

  // rule match against the symbols under the heads (tape RAMs keep head reads)
  always_comb begin
    logic [3:0] want;
    rule_hit = (rule_rdata.from_state == mstate);
    for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
      want = rule_rdata.match[4*k +: 4];
      if (k < int'(nt)) begin
        if (want == tmts_pkg::WILD_CODE) begin
          if (tape_rdata[k] == '0) rule_hit = 1'b0;
        end else if (want[tmts_pkg::SYM_BITS-1:0] != tape_rdata[k]) begin
          rule_hit = 1'b0;
        end
      end
    end
  end

  // memory port steering
  always_comb begin
    logic [3:0] w;
    rule_we    = 1'b0;
    rule_addr  = '0;
    rule_wdata = '{from_state: in_word.rule_from_state, match: in_word.rule_match_symbols,
                   write: in_word.rule_write_symbols, moves: in_word.rule_moves,
                   next_state: in_word.rule_next_state};
    if (state == tmts_pkg::S_IDLE && in_valid && in_word.opcode == tmts_pkg::OP_LOAD_RULE) begin
      rule_we   = (int'(in_word.rule_index) < tmts_pkg::NUM_RULES);
      rule_addr = in_word.rule_index[tmts_pkg::RULE_ABITS-1:0];
    end else if (state == tmts_pkg::S_SCAN) begin
      rule_addr = scan_idx_next[tmts_pkg::RULE_ABITS-1:0];
    end
    for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
      tape_addr[k]  = head[k];
      tape_we[k]    = 1'b0;
      tape_wdata[k] = '0;
      w = act_rule.write[4*k +: 4];
      unique case (state)
        tmts_pkg::S_CLEAR: begin
          tape_addr[k] = clr_cnt;
          tape_we[k]   = 1'b1;
        end
        tmts_pkg::S_IDLE: begin
          if (in_valid && int'(in_word.cell_tape) == k &&
              (in_word.opcode == tmts_pkg::OP_WRITE_CELL ||
               in_word.opcode == tmts_pkg::OP_READ_CELL)) begin
            tape_addr[k]  = in_word.cell_address[tmts_pkg::TAPE_ABITS-1:0];
            tape_we[k]    = (in_word.opcode == tmts_pkg::OP_WRITE_CELL) &&
                            (int'(in_word.cell_address) < tmts_pkg::TAPE_DEPTH);
            tape_wdata[k] = in_word.cell_symbol[tmts_pkg::SYM_BITS-1:0];
          end
        end
        tmts_pkg::S_APPLY: begin
          tape_we[k]    = (k < int'(nt)) && (w != tmts_pkg::WILD_CODE);
          tape_wdata[k] = w[tmts_pkg::SYM_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tmts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (in_word.opcode)
            tmts_pkg::OP_START:     state_next = tmts_pkg::S_CLEAR;
            tmts_pkg::OP_READ_CELL: state_next = tmts_pkg::S_READ;
            tmts_pkg::OP_STEP:      state_next = (halt_flag || limit == '0) ? tmts_pkg::S_DONE
                                                                            : tmts_pkg::S_SCAN;
            default:                state_next = tmts_pkg::S_DONE;
          endcase
        end
      end
      tmts_pkg::S_CLEAR: begin
        if (clr_cnt == tmts_pkg::TAPE_ABITS'(tmts_pkg::TAPE_DEPTH - 1)) begin
          state_next = clr_report ? tmts_pkg::S_DONE : tmts_pkg::S_IDLE;
        end
      end
      tmts_pkg::S_READ:  state_next = tmts_pkg::S_DONE;
      tmts_pkg::S_SCAN: begin
        if (rule_hit) state_next = tmts_pkg::S_APPLY;
        else if (scan_idx_next >= limit) state_next = tmts_pkg::S_DONE;
      end
      tmts_pkg::S_APPLY: state_next = tmts_pkg::S_DONE;
      tmts_pkg::S_DONE:  if (out_free) state_next = tmts_pkg::S_IDLE;
      default:           state_next = tmts_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= tmts_pkg::S_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    logic f;
    if (rst) begin
      initial_state <= '0;
      tapes_in_use  <= 3'd1;
      rules_in_use  <= '0;
      mstate        <= '0;
      steps         <= '0;
      halt_flag     <= 1'b0;
      fault_flag    <= 1'b0;
      clr_cnt       <= '0;
      clr_report    <= 1'b0;
      out_valid     <= 1'b0;
      for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
        head[k] <= tmts_pkg::TAPE_ABITS'(tmts_pkg::ORIGIN_EFF);
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tmts_pkg::CFG_INITIAL_STATE: initial_state <= cfg_data[7:0];
          tmts_pkg::CFG_TAPES_IN_USE:  tapes_in_use  <= cfg_data[2:0];
          tmts_pkg::CFG_RULES_IN_USE:  rules_in_use  <= cfg_data;
          default: ;
        endcase
      end
      if (state == tmts_pkg::S_DONE && out_free) out_valid <= 1'b1;
      else if (!out_stall)                       out_valid <= 1'b0;

      unique case (state)
        tmts_pkg::S_IDLE: begin
          if (accept) begin
            read_sym    <= '0;
            fired       <= '0;
            scan_idx    <= '0;
            clr_cnt     <= '0;
            clr_report  <= 1'b1;
            cell_tape_q <= in_word.cell_tape;
            if (in_word.opcode == tmts_pkg::OP_START) begin
              mstate     <= initial_state[tmts_pkg::STATE_BITS-1:0];
              steps      <= '0;
              halt_flag  <= 1'b0;
              fault_flag <= 1'b0;
              for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
                head[k] <= tmts_pkg::TAPE_ABITS'(tmts_pkg::ORIGIN_EFF);
              end
            end
            if (in_word.opcode == tmts_pkg::OP_STEP && !halt_flag && limit == '0) begin
              halt_flag <= 1'b1;
            end
          end
        end
        tmts_pkg::S_CLEAR: clr_cnt <= clr_cnt + 1'b1;
        tmts_pkg::S_READ: begin
          for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
            if (int'(cell_tape_q) == k) read_sym <= 4'(tape_rdata[k]);
          end
        end
        tmts_pkg::S_SCAN: begin
          if (rule_hit) begin
            act_rule <= rule_rdata;
            fired    <= scan_idx[7:0];
          end else if (scan_idx_next >= limit) begin
            halt_flag <= 1'b1;
          end
          scan_idx <= scan_idx_next;
        end
        tmts_pkg::S_APPLY: begin
          f = fault_flag;
          mstate <= act_rule.next_state[tmts_pkg::STATE_BITS-1:0];
          for (int k = 0; k < tmts_pkg::NUM_TAPES; k++) begin
            if (k < int'(nt)) begin
              if (act_rule.moves[2*k +: 2] == tmts_pkg::MOVE_LEFT) begin
                if (head[k] == '0) f = 1'b1;
                else head[k] <= head[k] - 1'b1;
              end else if (act_rule.moves[2*k +: 2] == tmts_pkg::MOVE_RIGHT) begin
                if (head[k] == tmts_pkg::TAPE_ABITS'(tmts_pkg::TAPE_DEPTH - 1)) f = 1'b1;
                else head[k] <= head[k] + 1'b1;
              end
            end
          end
          if (steps != '1) steps <= steps + 32'd1;
          fault_flag <= f;
          if (f) halt_flag <= 1'b1;
        end
        tmts_pkg::S_DONE: begin
          if (out_free) begin
            out_word  <= '{halted: halt_flag, head_fault: fault_flag,
                           present_state: 8'(mstate), steps_taken: steps,
                           read_symbol: read_sym, fired_rule: fired};
          end
        end
        default: ;
      endcase
    end
  end

endmodule
